>>> design/hmtn_pkg.sv
// Shared definitions for the heightmap tile normal core.
// Holds parameter defaults, lane counts and a width helper; no dependencies.
`default_nettype none
package hmtn_pkg;

    localparam int ELEV_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 14;

    // Lanes of the two normalization passes: six for the face pass, three for the mean.
    localparam int FACE_LANES = 6;
    localparam int MEAN_LANES = 3;

    // Round a bit count up to whole bytes.
    function automatic int byte_align(input int bits);
        return ((bits + 7) >> 3) << 3;
    endfunction

endpackage
`default_nettype wire

>>> design/hmtn_norm_unit.sv
// Pipelined normalizer lanes: restoring divide, then digit-by-digit square root.
// One step per stage, shared stall enable; no package dependencies.
`default_nettype none
module hmtn_norm_unit #(
    parameter int LANES     = 3,
    parameter int LEN_W     = 33,
    parameter int FRAC_BITS = 14,
    parameter int SIDE_W    = 2
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              en,
    input  wire                              in_valid,
    input  wire  [LANES-1:0][LEN_W-1:0]      num2,
    input  wire  [LANES-1:0][LEN_W-1:0]      den,
    input  wire  [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][FRAC_BITS:0]    q,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int QUO_W  = 2 * FRAC_BITS + 3;
    localparam int ROOT_W = FRAC_BITS + 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 3;
    localparam int DEPTH  = QUO_W + ROOT_W;

    // Quotient floor(num2 * 4^(F+1) / den), one bit per stage, MSB first.
    logic [LANES-1:0][LEN_W-1:0]  den_reg   [QUO_W-1];
    logic [LANES-1:0][LEN_W-1:0]  den_next  [QUO_W-1];
    logic [LANES-1:0][LEN_W-1:0]  drem_reg  [QUO_W-1];
    logic [LANES-1:0][LEN_W-1:0]  drem_next [QUO_W-1];
    logic [LANES-1:0][QUO_W-1:0]  quo_reg   [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]  quo_next  [QUO_W];

    // Integer square root of the quotient, two radicand bits per stage.
    logic [LANES-1:0][RAD_W-1:0]  rad_reg   [ROOT_W-1];
    logic [LANES-1:0][RAD_W-1:0]  rad_next  [ROOT_W-1];
    logic [LANES-1:0][SREM_W-1:0] srem_reg  [ROOT_W-1];
    logic [LANES-1:0][SREM_W-1:0] srem_next [ROOT_W-1];
    logic [LANES-1:0][ROOT_W-1:0] root_reg  [ROOT_W];
    logic [LANES-1:0][ROOT_W-1:0] root_next [ROOT_W];

    logic [DEPTH-1:0]  vld_reg;
    logic [SIDE_W-1:0] side_reg [DEPTH];

    // Returns {quotient bit, new remainder}.
    function automatic logic [LEN_W:0] div_step(input logic [LEN_W:0] trial,
                                                input logic [LEN_W-1:0] dv);
        logic [LEN_W:0] diff;
        diff = trial - {1'b0, dv};
        if (trial >= {1'b0, dv}) begin
            return {1'b1, diff[LEN_W-1:0]};
        end
        return {1'b0, trial[LEN_W-1:0]};
    endfunction

    // Returns {new root, new remainder}.
    function automatic logic [ROOT_W+SREM_W-1:0] sqrt_step(input logic [SREM_W-1:0] rem,
                                                           input logic [ROOT_W-1:0] root,
                                                           input logic [1:0]        bits);
        logic [SREM_W-1:0] cur;
        logic [SREM_W-1:0] trial;
        cur   = {rem[SREM_W-3:0], bits};
        trial = {1'b0, root, 2'b01};
        if (cur >= trial) begin
            return {root[ROOT_W-2:0], 1'b1, cur - trial};
        end
        return {root[ROOT_W-2:0], 1'b0, cur};
    endfunction

    always_comb begin : p_div
        logic [LEN_W:0] step;
        for (int l = 0; l < LANES; l++) begin
            step              = div_step({1'b0, num2[l]}, den[l]);
            den_next[0][l]    = den[l];
            drem_next[0][l]   = step[LEN_W-1:0];
            quo_next[0][l]    = QUO_W'(step[LEN_W]);
        end
        for (int i = 1; i < QUO_W; i++) begin
            for (int l = 0; l < LANES; l++) begin
                step = div_step({drem_reg[i-1][l], 1'b0}, den_reg[i-1][l]);
                quo_next[i][l] = {quo_reg[i-1][l][QUO_W-2:0], step[LEN_W]};
                if (i < QUO_W - 1) begin
                    den_next[i][l]  = den_reg[i-1][l];
                    drem_next[i][l] = step[LEN_W-1:0];
                end
            end
        end
    end

    always_comb begin : p_sqrt
        logic [ROOT_W+SREM_W-1:0] step;
        logic [RAD_W-1:0]         rad0;
        for (int l = 0; l < LANES; l++) begin
            rad0             = {1'b0, quo_reg[QUO_W-1][l]};
            step             = sqrt_step('0, '0, rad0[RAD_W-1 -: 2]);
            root_next[0][l]  = step[ROOT_W+SREM_W-1:SREM_W];
            srem_next[0][l]  = step[SREM_W-1:0];
            rad_next[0][l]   = rad0 << 2;
        end
        for (int j = 1; j < ROOT_W; j++) begin
            for (int l = 0; l < LANES; l++) begin
                step = sqrt_step(srem_reg[j-1][l], root_reg[j-1][l],
                                 rad_reg[j-1][l][RAD_W-1 -: 2]);
                root_next[j][l] = step[ROOT_W+SREM_W-1:SREM_W];
                if (j < ROOT_W - 1) begin
                    srem_next[j][l] = step[SREM_W-1:0];
                    rad_next[j][l]  = rad_reg[j-1][l] << 2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg  <= den_next;
            drem_reg <= drem_next;
            quo_reg  <= quo_next;
            rad_reg  <= rad_next;
            srem_reg <= srem_next;
            root_reg <= root_next;
            side_reg[0] <= in_side;
            for (int k = 1; k < DEPTH; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // Round: largest q with (2q-1)^2 <= quotient is (root + 1) / 2.
    always_comb begin : p_round
        logic [ROOT_W-1:0] root_inc;
        for (int l = 0; l < LANES; l++) begin
            root_inc = root_reg[ROOT_W-1][l] + 1'b1;
            q[l]     = root_inc[ROOT_W-1:1];
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_side  = side_reg[DEPTH-1];

endmodule
`default_nettype wire

>>> design/hmtn_out_buf.sv
// Output register with a skid entry for the normal core.
// Parts the pipeline stall from the receiver's tready; no package dependencies.
`default_nettype none
module hmtn_out_buf #(
    parameter int DATA_W = 48
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    input  wire  [DATA_W-1:0]   in_data,
    output logic                advance,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [DATA_W-1:0]   out_data
);

    logic              out_vld_reg;
    logic              skid_vld_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              take;
    logic              arrive;

    // Pipeline moves only while the skid entry is free.
    assign advance = !skid_vld_reg;
    assign take    = out_vld_reg && out_ready;
    assign arrive  = in_valid && !skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (take) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (out_vld_reg && !take) begin
            if (arrive) begin
                skid_vld_reg <= 1'b1;
            end
        end else begin
            out_vld_reg <= arrive;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (out_vld_reg && !take) begin
            if (arrive) begin
                skid_data_reg <= in_data;
            end
        end else if (arrive) begin
            out_data_reg <= in_data;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

>>> design/heightmap_tile_normal_core.sv
// Top level of the heightmap tile normal core: slope, face and mean passes.
// Depends on hmtn_pkg, hmtn_norm_unit and hmtn_out_buf.
//
// Usage: each s_ word carries the four corner elevations of one unit tile. The
// core forms the face normals of triangles TL-TR-BR and TL-BR-BL, normalizes
// each, sums the two unit normals and normalizes the sum. The m_ word holds the
// unit normal in signed fixed point, 1 << FRAC_BITS meaning 1.0.
// Throughput: one word per cycle while the output is not stalled, with no dependence between tiles.
// Depth: set mostly by the two normalizer passes, each 3*FRAC_BITS + 5 stages
// deep: one quotient bit per stage of a restoring divide, then one root bit per
// stage of a square root; seven slope, square and sum stages after the input
// register and the output register make up the rest.
// Reset: aresetn low clears all valid bits; s_tready stays low during reset and
// rises the cycle after it is released.
// Stall: a finished word waits in the output register while the pipeline keeps
// taking words; one more word lands in a skid entry, and only then do the
// pipeline and s_tready hold until m_tready drains it. No word is dropped or
// repeated.
`default_nettype none
module heightmap_tile_normal_core #(
    parameter int  ELEV_BITS = hmtn_pkg::ELEV_BITS_DEF,
    parameter int  FRAC_BITS = hmtn_pkg::FRAC_BITS_DEF,
    localparam int IN_W      = hmtn_pkg::byte_align(4 * ELEV_BITS),
    localparam int OUT_W     = hmtn_pkg::byte_align(3 * FRAC_BITS + 5)
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    // elev_top_left, elev_top_right, elev_bottom_right, elev_bottom_left
    // (ELEV_BITS each, signed), zero pad
    input  wire  [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  wire                m_tready,
    // normal_x (FRAC_BITS+2, signed), normal_y (FRAC_BITS+2, signed),
    // normal_z (FRAC_BITS+1, unsigned), zero pad
    output logic [OUT_W-1:0]   m_tdata
);

    import hmtn_pkg::*;

    localparam int SQ_W      = 2 * ELEV_BITS;
    localparam int L1_W      = SQ_W + 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int MAG_W     = FRAC_BITS + 2;
    localparam int SUM_W     = FRAC_BITS + 3;
    localparam int L2_W      = 2 * MAG_W;

    logic en;
    logic run_reg;

    // Front stages: input, slopes, squares, face lengths.
    logic [3:0]           pre_vld_reg;
    logic [ELEV_BITS-1:0] elev_reg  [4];
    logic [ELEV_BITS-1:0] slope_reg [4];
    logic [3:0]           s2_neg_reg;
    logic [SQ_W-1:0]      sq_reg    [4];
    logic [3:0]           s3_neg_reg;
    logic [SQ_W-1:0]      lsq_reg   [4];
    logic [L1_W-1:0]      len1_reg  [2];
    logic [3:0]           s4_neg_reg;

    logic [FACE_LANES-1:0][L1_W-1:0] face_num;
    logic [FACE_LANES-1:0][L1_W-1:0] face_den;
    logic                            face_vld;
    logic [FACE_LANES-1:0][Q_W-1:0]  face_q;
    logic [3:0]                      face_neg;

    // Middle stages: sum, sign split, squares, mean length.
    logic [3:0]       mid_vld_reg;
    logic [SUM_W-1:0] sx_reg;
    logic [SUM_W-1:0] sy_reg;
    logic [MAG_W-1:0] sz_reg;
    logic [MAG_W-1:0] mx_reg;
    logic [MAG_W-1:0] my_reg;
    logic [MAG_W-1:0] mz_reg;
    logic [1:0]       s6_neg_reg;
    logic [L2_W-1:0]  sqx_reg;
    logic [L2_W-1:0]  sqy_reg;
    logic [L2_W-1:0]  sqz_reg;
    logic [1:0]       s7_neg_reg;
    logic             s7_zero_reg;
    logic [L2_W-1:0]  lsqx_reg;
    logic [L2_W-1:0]  lsqy_reg;
    logic [L2_W-1:0]  lsqz_reg;
    logic [L2_W-1:0]  len2_reg;
    logic [1:0]       s8_neg_reg;
    logic             s8_zero_reg;

    logic [MEAN_LANES-1:0][L2_W-1:0] mean_num;
    logic [MEAN_LANES-1:0][L2_W-1:0] mean_den;
    logic                            mean_vld;
    logic [MEAN_LANES-1:0][Q_W-1:0]  mean_q;
    logic [2:0]                      mean_side;

    logic [MAG_W-1:0]  nx;
    logic [MAG_W-1:0]  ny;
    logic [Q_W-1:0]    nz;
    logic [OUT_W-1:0]  res_data;

    // Signed difference p - q as {sign, magnitude}.
    function automatic logic [ELEV_BITS:0] slope(input logic [ELEV_BITS-1:0] p,
                                                 input logic [ELEV_BITS-1:0] q);
        logic [ELEV_BITS:0] fwd;
        logic [ELEV_BITS:0] bwd;
        fwd = {p[ELEV_BITS-1], p} - {q[ELEV_BITS-1], q};
        bwd = {q[ELEV_BITS-1], q} - {p[ELEV_BITS-1], p};
        return fwd[ELEV_BITS] ? {1'b1, bwd[ELEV_BITS-1:0]} : {1'b0, fwd[ELEV_BITS-1:0]};
    endfunction

    function automatic logic [SUM_W-1:0] apply_sign(input logic [Q_W-1:0] v,
                                                    input logic       neg);
        logic [SUM_W-1:0] e;
        e = SUM_W'(v);
        return neg ? -e : e;
    endfunction

    // Two's complement sum as {sign, magnitude}.
    function automatic logic [MAG_W:0] split_sign(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] n;
        n = -v;
        return v[SUM_W-1] ? {1'b1, n[MAG_W-1:0]} : {1'b0, v[MAG_W-1:0]};
    endfunction

    // Hold input off during reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
        end
    end

    assign s_tready = run_reg && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg <= '0;
            mid_vld_reg <= '0;
        end else if (en) begin
            pre_vld_reg <= {pre_vld_reg[2:0], s_tvalid && run_reg};
            mid_vld_reg <= {mid_vld_reg[2:0], face_vld};
        end
    end

    // Front: slopes x1 = a-b, y1 = b-c, x2 = d-c, y2 = a-d.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                elev_reg[k] <= s_tdata[k*ELEV_BITS +: ELEV_BITS];
            end
            {s2_neg_reg[0], slope_reg[0]} <= slope(elev_reg[0], elev_reg[1]);
            {s2_neg_reg[1], slope_reg[1]} <= slope(elev_reg[1], elev_reg[2]);
            {s2_neg_reg[2], slope_reg[2]} <= slope(elev_reg[3], elev_reg[2]);
            {s2_neg_reg[3], slope_reg[3]} <= slope(elev_reg[0], elev_reg[3]);
            for (int k = 0; k < 4; k++) begin
                sq_reg[k] <= SQ_W'(slope_reg[k]) * SQ_W'(slope_reg[k]);
            end
            s3_neg_reg <= s2_neg_reg;
            lsq_reg    <= sq_reg;
            len1_reg[0] <= L1_W'(sq_reg[0]) + L1_W'(sq_reg[1]) + L1_W'(1);
            len1_reg[1] <= L1_W'(sq_reg[2]) + L1_W'(sq_reg[3]) + L1_W'(1);
            s4_neg_reg <= s3_neg_reg;
        end
    end

    // Face lanes: x1, y1, z1 over len1[0]; x2, y2, z2 over len1[1].
    assign face_num[0] = L1_W'(lsq_reg[0]);
    assign face_num[1] = L1_W'(lsq_reg[1]);
    assign face_num[2] = L1_W'(1);
    assign face_num[3] = L1_W'(lsq_reg[2]);
    assign face_num[4] = L1_W'(lsq_reg[3]);
    assign face_num[5] = L1_W'(1);
    assign face_den[0] = len1_reg[0];
    assign face_den[1] = len1_reg[0];
    assign face_den[2] = len1_reg[0];
    assign face_den[3] = len1_reg[1];
    assign face_den[4] = len1_reg[1];
    assign face_den[5] = len1_reg[1];

    hmtn_norm_unit #(
        .LANES     (FACE_LANES),
        .LEN_W     (L1_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (4)
    ) u_face_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pre_vld_reg[3]),
        .num2      (face_num),
        .den       (face_den),
        .in_side   (s4_neg_reg),
        .out_valid (face_vld),
        .q         (face_q),
        .out_side  (face_neg)
    );

    // Middle: sum the two unit faces, split sign, square, mean length.
    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= apply_sign(face_q[0], face_neg[0]) + apply_sign(face_q[3], face_neg[2]);
            sy_reg <= apply_sign(face_q[1], face_neg[1]) + apply_sign(face_q[4], face_neg[3]);
            sz_reg <= MAG_W'(face_q[2]) + MAG_W'(face_q[5]);
            {s6_neg_reg[0], mx_reg} <= split_sign(sx_reg);
            {s6_neg_reg[1], my_reg} <= split_sign(sy_reg);
            mz_reg <= sz_reg;
            sqx_reg <= L2_W'(mx_reg) * L2_W'(mx_reg);
            sqy_reg <= L2_W'(my_reg) * L2_W'(my_reg);
            sqz_reg <= L2_W'(mz_reg) * L2_W'(mz_reg);
            s7_neg_reg  <= s6_neg_reg;
            s7_zero_reg <= (mx_reg == '0) && (my_reg == '0) && (mz_reg == '0);
            lsqx_reg <= sqx_reg;
            lsqy_reg <= sqy_reg;
            lsqz_reg <= sqz_reg;
            len2_reg <= sqx_reg + sqy_reg + sqz_reg;
            s8_neg_reg  <= s7_neg_reg;
            s8_zero_reg <= s7_zero_reg;
        end
    end

    assign mean_num[0] = lsqx_reg;
    assign mean_num[1] = lsqy_reg;
    assign mean_num[2] = lsqz_reg;
    assign mean_den[0] = len2_reg;
    assign mean_den[1] = len2_reg;
    assign mean_den[2] = len2_reg;

    hmtn_norm_unit #(
        .LANES     (MEAN_LANES),
        .LEN_W     (L2_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (3)
    ) u_mean_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mid_vld_reg[3]),
        .num2      (mean_num),
        .den       (mean_den),
        .in_side   ({s8_zero_reg, s8_neg_reg}),
        .out_valid (mean_vld),
        .q         (mean_q),
        .out_side  (mean_side)
    );

    // Restore signs; when the faces cancel, point straight up.
    always_comb begin
        if (mean_side[2]) begin
            nx = '0;
            ny = '0;
            nz = {1'b1, {FRAC_BITS{1'b0}}};
        end else begin
            nx = mean_side[0] ? -MAG_W'(mean_q[0]) : MAG_W'(mean_q[0]);
            ny = mean_side[1] ? -MAG_W'(mean_q[1]) : MAG_W'(mean_q[1]);
            nz = mean_q[2];
        end
    end

    assign res_data = OUT_W'({nz, ny, nx});

    hmtn_out_buf #(
        .DATA_W (OUT_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mean_vld),
        .in_data   (res_data),
        .advance   (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire
